// File: hw/rtl/sdspi_pkg.sv
// sdspi_pkg: phase codes, status codes and command table of the sd spi host sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sdspi_pkg;

  typedef enum logic [4:0] {
    P_IDLE        = 5'd0,
    P_POWER       = 5'd1,
    P_GO_IDLE     = 5'd2,
    P_IF_COND     = 5'd3,
    P_R7          = 5'd4,
    P_OCR_FIRST   = 5'd5,
    P_R3_FIRST    = 5'd6,
    P_APP_V2      = 5'd7,
    P_OPCOND_V2   = 5'd8,
    P_OCR_SECOND  = 5'd9,
    P_R3_SECOND   = 5'd10,
    P_APP_PROBE   = 5'd11,
    P_OPCOND_V1   = 5'd12,
    P_APP_V1      = 5'd13,
    P_MMC_OP      = 5'd14,
    P_CRC_OFF     = 5'd15,
    P_BLOCKLEN    = 5'd16,
    P_READ_CMD    = 5'd17,
    P_READ_TOKEN  = 5'd18,
    P_READ_DATA   = 5'd19,
    P_READ_CRC    = 5'd20,
    P_WRITE_CMD   = 5'd21,
    P_WRITE_GAP   = 5'd22,
    P_WRITE_START = 5'd23,
    P_WRITE_DATA  = 5'd24,
    P_WRITE_CRC   = 5'd25,
    P_WRITE_RESP  = 5'd26,
    P_WRITE_BUSY  = 5'd27
  } phase_t;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_XCHG  = 2'd3;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TIMEOUT   = 4'd1;
  localparam logic [3:0] ST_VOLTAGE   = 4'd2;
  localparam logic [3:0] ST_PATTERN   = 4'd3;
  localparam logic [3:0] ST_ILLEGAL   = 4'd4;
  localparam logic [3:0] ST_RD_CMD    = 4'd5;
  localparam logic [3:0] ST_RD_TOKEN  = 4'd6;
  localparam logic [3:0] ST_WR_CMD    = 4'd7;
  localparam logic [3:0] ST_WR_REJECT = 4'd8;

  localparam logic [1:0] KIND_V1  = 2'd0;
  localparam logic [1:0] KIND_V2  = 2'd1;
  localparam logic [1:0] KIND_HC  = 2'd2;
  localparam logic [1:0] KIND_MMC = 2'd3;

  localparam logic [1:0] CFG_POLL  = 2'd0;
  localparam logic [1:0] CFG_IDLE  = 2'd1;
  localparam logic [1:0] CFG_READY = 2'd2;

  typedef struct packed {
    logic       is_cmd;
    logic [5:0] code;
  } cmd_info_t;

  function automatic cmd_info_t cmd_of(input phase_t p);
    cmd_info_t c;
    c.is_cmd = 1'b1;
    c.code   = 6'd0;
    unique case (p)
      P_GO_IDLE:    c.code = 6'd0;
      P_IF_COND:    c.code = 6'd8;
      P_OCR_FIRST,
      P_OCR_SECOND: c.code = 6'd58;
      P_APP_V2,
      P_APP_PROBE,
      P_APP_V1:     c.code = 6'd55;
      P_OPCOND_V2,
      P_OPCOND_V1:  c.code = 6'd41;
      P_MMC_OP:     c.code = 6'd1;
      P_CRC_OFF:    c.code = 6'd59;
      P_BLOCKLEN:   c.code = 6'd16;
      P_READ_CMD:   c.code = 6'd17;
      P_WRITE_CMD:  c.code = 6'd24;
      default:      c.is_cmd = 1'b0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sdspi_core.sv
// sdspi_core: next-state and result logic for one item of the sd spi sequencer
// depends on sdspi_pkg
`timescale 1ns / 1ps
`default_nettype none
module sdspi_core import sdspi_pkg::*; #(
  parameter int BLOCK_BYTES = 512
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic [1:0]   opcode,
  input  wire logic [31:0]  block_number,
  input  wire logic [7:0]   rx_byte,
  input  wire logic [7:0]   write_byte,
  input  wire logic [11:0]  poll_limit,
  input  wire logic [9:0]   idle_limit,
  input  wire logic [10:0]  ready_limit,
  output logic      [7:0]   tx_byte,
  output logic              tx_valid,
  output logic              chip_select_high,
  output logic      [7:0]   read_data,
  output logic              read_valid,
  output logic              write_taken,
  output logic              done_res,
  output logic      [3:0]   status,
  output logic      [1:0]   card_kind
);

  localparam int BW = $clog2(BLOCK_BYTES + 1);
  localparam int CW = (BW > 4) ? BW : 4;
  localparam logic [CW-1:0] BLK_CNT = CW'(BLOCK_BYTES);
  localparam logic [31:0]   BLK_LEN = 32'(BLOCK_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [CW-1:0] byte_count_r, byte_count_nxt;
  logic [11:0] poll_count_r, poll_count_nxt;
  logic [10:0] retry_count_r, retry_count_nxt;
  logic [7:0]  resp_r [4];
  logic [7:0]  resp_nxt [4];
  logic [1:0]  kind_r, kind_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [7:0]  last_resp_r, last_resp_nxt;

  logic        done_c, rv_c;
  logic [3:0]  st_c;
  logic [7:0]  rd_c;
  logic [11:0] plim;
  logic [9:0]  ilim;
  logic [10:0] rlim;
  logic [11:0] poll_inc;
  logic [10:0] retry_inc;
  logic [CW-1:0] bc_inc;
  cmd_info_t   ci, co;
  logic [31:0] ca;

  assign plim      = (poll_limit == '0) ? 12'd1 : poll_limit;
  assign ilim      = (idle_limit == '0) ? 10'd1 : idle_limit;
  assign rlim      = (ready_limit == '0) ? 11'd1 : ready_limit;
  assign poll_inc  = poll_count_r + 12'd1;
  assign retry_inc = retry_count_r + 11'd1;
  assign bc_inc    = byte_count_r + CW'(1);
  assign ci        = cmd_of(phase_r);

  always_comb begin
    phase_nxt       = phase_r;
    byte_count_nxt  = byte_count_r;
    poll_count_nxt  = poll_count_r;
    retry_count_nxt = retry_count_r;
    for (int i = 0; i < 4; i++) resp_nxt[i] = resp_r[i];
    kind_nxt      = kind_r;
    addr_nxt      = addr_r;
    last_resp_nxt = last_resp_r;
    done_c = 1'b0;
    rv_c   = 1'b0;
    st_c   = ST_OK;
    rd_c   = 8'd0;
    if (opcode == OP_INIT) begin
      phase_nxt = P_POWER; byte_count_nxt = '0; poll_count_nxt = '0;
    end else if (opcode == OP_READ || opcode == OP_WRITE) begin
      addr_nxt = (kind_r == KIND_HC) ? block_number : 32'(block_number * BLK_LEN);
      phase_nxt = (opcode == OP_READ) ? P_READ_CMD : P_WRITE_CMD;
      byte_count_nxt = '0; poll_count_nxt = '0;
    end else if (phase_r != P_IDLE) begin
      if (ci.is_cmd) begin
        if (byte_count_r < CW'(7)) begin
          byte_count_nxt = bc_inc; poll_count_nxt = '0;
        end else begin
          poll_count_nxt = poll_inc;
          if (rx_byte != 8'hFF || poll_inc >= plim) begin
            last_resp_nxt  = rx_byte;
            byte_count_nxt = '0;
            poll_count_nxt = '0;
            case (phase_r)
              P_GO_IDLE: begin
                retry_count_nxt = retry_inc;
                if (rx_byte == 8'h01) phase_nxt = P_IF_COND;
                else if (retry_inc >= {1'b0, ilim}) begin
                  phase_nxt = P_IDLE; done_c = 1'b1; st_c = ST_TIMEOUT;
                end
              end
              P_IF_COND: phase_nxt = rx_byte[2] ? P_APP_PROBE : P_R7;
              P_OCR_FIRST: phase_nxt = P_R3_FIRST;
              P_APP_V2: phase_nxt = P_OPCOND_V2;
              P_OPCOND_V2: begin
                retry_count_nxt = retry_inc;
                if (!rx_byte[0]) phase_nxt = P_OCR_SECOND;
                else if (retry_inc >= rlim) begin
                  phase_nxt = P_IDLE; done_c = 1'b1; st_c = ST_TIMEOUT;
                end else phase_nxt = P_APP_V2;
              end
              P_OCR_SECOND: phase_nxt = P_R3_SECOND;
              P_APP_PROBE: begin
                retry_count_nxt = '0;
                if (!rx_byte[2]) begin
                  kind_nxt = KIND_V1; phase_nxt = P_OPCOND_V1;
                end else begin
                  kind_nxt = KIND_MMC; phase_nxt = P_MMC_OP;
                end
              end
              P_OPCOND_V1: begin
                if (!rx_byte[0]) phase_nxt = P_CRC_OFF;
                else begin
                  retry_count_nxt = retry_inc;
                  if (retry_inc >= rlim) begin
                    phase_nxt = P_IDLE; done_c = 1'b1; st_c = ST_TIMEOUT;
                  end else phase_nxt = P_APP_V1;
                end
              end
              P_APP_V1: phase_nxt = P_OPCOND_V1;
              P_MMC_OP: begin
                retry_count_nxt = retry_inc;
                if (rx_byte == 8'h00) phase_nxt = P_CRC_OFF;
                else if (retry_inc >= rlim) begin
                  phase_nxt = P_IDLE; done_c = 1'b1; st_c = ST_TIMEOUT;
                end
              end
              P_CRC_OFF: begin
                if (rx_byte != 8'h00) begin
                  phase_nxt = P_IDLE; done_c = 1'b1; st_c = ST_ILLEGAL;
                end else phase_nxt = P_BLOCKLEN;
              end
              P_BLOCKLEN: begin
                phase_nxt = P_IDLE; done_c = 1'b1;
                st_c = (rx_byte != 8'h00) ? ST_ILLEGAL : ST_OK;
              end
              P_READ_CMD: begin
                if (rx_byte != 8'h00) begin
                  phase_nxt = P_IDLE; done_c = 1'b1; st_c = ST_RD_CMD;
                end else phase_nxt = P_READ_TOKEN;
              end
              P_WRITE_CMD: begin
                if (rx_byte != 8'h00) begin
                  phase_nxt = P_IDLE; done_c = 1'b1; st_c = ST_WR_CMD;
                end else phase_nxt = P_WRITE_GAP;
              end
              default: phase_nxt = P_IDLE;
            endcase
          end
        end
      end else begin
        case (phase_r)
          P_POWER: begin
            byte_count_nxt = bc_inc;
            if (bc_inc >= CW'(10)) begin
              retry_count_nxt = '0; phase_nxt = P_GO_IDLE;
              byte_count_nxt = '0; poll_count_nxt = '0;
            end
          end
          P_R7, P_R3_FIRST, P_R3_SECOND: begin
            resp_nxt[byte_count_r[1:0]] = rx_byte;
            byte_count_nxt = bc_inc;
            if (bc_inc >= CW'(4)) begin
              byte_count_nxt = '0; poll_count_nxt = '0;
              if (phase_r == P_R7) begin
                if (resp_nxt[2] != 8'h01) begin
                  phase_nxt = P_IDLE; done_c = 1'b1; st_c = ST_VOLTAGE;
                end else if (resp_nxt[3] != 8'h22) begin
                  phase_nxt = P_IDLE; done_c = 1'b1; st_c = ST_PATTERN;
                end else phase_nxt = P_OCR_FIRST;
              end else if (phase_r == P_R3_FIRST) begin
                retry_count_nxt = '0; phase_nxt = P_APP_V2;
              end else begin
                kind_nxt = resp_nxt[0][6] ? KIND_HC : KIND_V2;
                phase_nxt = P_CRC_OFF;
              end
            end
          end
          P_READ_TOKEN: begin
            last_resp_nxt = rx_byte;
            if (rx_byte == 8'hFE) begin
              phase_nxt = P_READ_DATA; byte_count_nxt = '0; poll_count_nxt = '0;
            end else if ((rx_byte & 8'hF1) == 8'h01) begin
              phase_nxt = P_IDLE; done_c = 1'b1; st_c = ST_RD_TOKEN;
              byte_count_nxt = '0; poll_count_nxt = '0;
            end
          end
          P_READ_DATA: begin
            rv_c = 1'b1; rd_c = rx_byte;
            byte_count_nxt = bc_inc;
            if (bc_inc >= BLK_CNT) begin
              phase_nxt = P_READ_CRC; byte_count_nxt = '0; poll_count_nxt = '0;
            end
          end
          P_READ_CRC: begin
            byte_count_nxt = bc_inc;
            if (bc_inc >= CW'(2)) begin
              phase_nxt = P_IDLE; done_c = 1'b1;
              byte_count_nxt = '0; poll_count_nxt = '0;
            end
          end
          P_WRITE_GAP: begin
            phase_nxt = P_WRITE_START; byte_count_nxt = '0; poll_count_nxt = '0;
          end
          P_WRITE_START: begin
            phase_nxt = P_WRITE_DATA; byte_count_nxt = '0; poll_count_nxt = '0;
          end
          P_WRITE_DATA: begin
            byte_count_nxt = bc_inc;
            if (bc_inc >= BLK_CNT) begin
              phase_nxt = P_WRITE_CRC; byte_count_nxt = '0; poll_count_nxt = '0;
            end
          end
          P_WRITE_CRC: begin
            byte_count_nxt = bc_inc;
            if (bc_inc >= CW'(2)) begin
              phase_nxt = P_WRITE_RESP; byte_count_nxt = '0; poll_count_nxt = '0;
            end
          end
          P_WRITE_RESP: begin
            last_resp_nxt = rx_byte;
            byte_count_nxt = '0; poll_count_nxt = '0;
            if ((rx_byte & 8'h1F) != 8'h05) begin
              phase_nxt = P_IDLE; done_c = 1'b1; st_c = ST_WR_REJECT;
            end else phase_nxt = P_WRITE_BUSY;
          end
          P_WRITE_BUSY: begin
            if (rx_byte != 8'h00) begin
              phase_nxt = P_IDLE; done_c = 1'b1;
              byte_count_nxt = '0; poll_count_nxt = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // command code and argument for the phase being entered
  assign co = cmd_of(phase_nxt);
  always_comb begin
    unique case (phase_nxt)
      P_IF_COND:               ca = 32'h00000122;
      P_OPCOND_V2:             ca = 32'h40000000;
      P_BLOCKLEN:              ca = BLK_LEN;
      P_READ_CMD, P_WRITE_CMD: ca = addr_nxt;
      default:                 ca = 32'd0;
    endcase
  end

  logic [7:0] tx_c;
  logic       wt_c;
  always_comb begin
    tx_c = 8'hFF;
    wt_c = 1'b0;
    if (co.is_cmd) begin
      case (byte_count_nxt)
        CW'(1): tx_c = {2'b01, co.code};
        CW'(2): tx_c = ca[31:24];
        CW'(3): tx_c = ca[23:16];
        CW'(4): tx_c = ca[15:8];
        CW'(5): tx_c = ca[7:0];
        CW'(6): tx_c = 8'h95;
        default: tx_c = 8'hFF;
      endcase
    end else if (phase_nxt == P_WRITE_START) begin
      tx_c = 8'hFE;
    end else if (phase_nxt == P_WRITE_DATA) begin
      tx_c = write_byte;
      wt_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= P_IDLE;
      byte_count_r  <= '0;
      poll_count_r  <= '0;
      retry_count_r <= '0;
      kind_r        <= KIND_V1;
      addr_r        <= '0;
      last_resp_r   <= 8'hFF;
    end else if (step) begin
      phase_r       <= phase_nxt;
      byte_count_r  <= byte_count_nxt;
      poll_count_r  <= poll_count_nxt;
      retry_count_r <= retry_count_nxt;
      kind_r        <= kind_nxt;
      addr_r        <= addr_nxt;
      last_resp_r   <= last_resp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 4; i++) resp_r[i] <= resp_nxt[i];
      tx_byte          <= tx_c;
      tx_valid         <= (phase_nxt != P_IDLE);
      chip_select_high <= (phase_nxt == P_IDLE) || (phase_nxt == P_POWER);
      read_data        <= rd_c;
      read_valid       <= rv_c;
      write_taken      <= wt_c;
      done_res         <= done_c;
      status           <= st_c;
      card_kind        <= kind_nxt;
    end
  end

  // last response is kept internally; it reaches no output and only feeds unused_ok
  logic unused_ok;
  assign unused_ok = ^last_resp_r;

endmodule
`default_nettype wire

// File: hw/rtl/sd_card_spi_mode_host_sequencer.sv
// sd spi host sequencer: one registered item in, one result item out per cycle unless stalled
// item path: input register, then result register, written only when the output is free
// throughput: one item per cycle while the output is not stalled; single-pass next-state logic
// reset: synchronous active-low rst_n; phase idle, counters zero, limits 2500/250/1024
// depends on sdspi_pkg and sdspi_core
`timescale 1ns / 1ps
`default_nettype none
module sd_card_spi_mode_host_sequencer import sdspi_pkg::*; #(
  parameter int BLOCK_BYTES = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // opcode, block_number, rx_byte, write_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // tx_byte, tx_valid, chip_select_high, read_data,
                                       // read_valid, write_taken, done_res, status, card_kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  logic        in_v_r;
  logic [55:0] in_d_r;
  logic        out_v_r;
  logic        step;
  logic [11:0] poll_lim_r;
  logic [9:0]  idle_lim_r;
  logic [10:0] ready_lim_r;

  logic [7:0] tx_byte, read_data;
  logic       tx_valid, cs_high, read_valid, write_taken, done_res;
  logic [3:0] status;
  logic [1:0] card_kind;

  assign step      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) in_v_r <= in_tvalid;
      if (step) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_d_r <= in_tdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_lim_r  <= 12'd2500;
      idle_lim_r  <= 10'd250;
      ready_lim_r <= 11'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POLL:  poll_lim_r  <= cfg_data;
        CFG_IDLE:  idle_lim_r  <= cfg_data[9:0];
        CFG_READY: ready_lim_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  sdspi_core #(.BLOCK_BYTES(BLOCK_BYTES)) u_core (
    .clk, .rst_n, .step,
    .opcode(in_d_r[1:0]), .block_number(in_d_r[33:2]),
    .rx_byte(in_d_r[41:34]), .write_byte(in_d_r[49:42]),
    .poll_limit(poll_lim_r), .idle_limit(idle_lim_r), .ready_limit(ready_lim_r),
    .tx_byte, .tx_valid, .chip_select_high(cs_high), .read_data, .read_valid,
    .write_taken, .done_res, .status, .card_kind
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, card_kind, status, done_res, write_taken, read_valid,
                       read_data, cs_high, tx_valid, tx_byte};

endmodule
`default_nettype wire

// File: hw/rtl/sdspi_checker.sv
// sdspi_checker: port-level checks of the sd spi host sequencer, bound to the top level
// depends on sdspi_pkg
`timescale 1ns / 1ps
`default_nettype none
module sdspi_checker import sdspi_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[20] |-> out_tdata[24:21] == ST_OK)
    else $error("status without done");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |-> !out_tdata[8] && out_tdata[9])
    else $error("done while active");

  a_tx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[7:0] == 8'hFF && !out_tdata[19])
    else $error("byte driven while idle");

endmodule

bind sd_card_spi_mode_host_sequencer sdspi_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);
`default_nettype wire
